### rtl/core/cfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the command frame parser.
// No dependencies; imported by every module of the block.
package cfp_pkg;

    // Result kinds on the master side
    localparam logic [1:0] EV_DEGREE = 2'd0;
    localparam logic [1:0] EV_ACK    = 2'd1;
    localparam logic [1:0] EV_HEART  = 2'd2;

    // Input beat kinds
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Link byte values
    localparam logic [7:0] SYNC_BYTE     = 8'hFE;
    localparam logic [7:0] HB_HEAD_BYTE  = 8'h27;
    localparam logic [7:0] HB_TAIL_BYTE  = 8'h0F;
    localparam logic [7:0] DEG_CMD_BYTE  = 8'hE0;
    localparam logic [7:0] DEG_ARG_BYTE  = 8'h00;
    localparam logic [7:0] ACK_CMD_BYTE  = 8'hE2;
    localparam logic [7:0] ACK_ARG1_BYTE = 8'h01;
    localparam logic [7:0] ACK_ARG2_BYTE = 8'h02;

    typedef struct packed {
        logic [1:0] event_res;
        logic [1:0] ack_code;
    } cfp_result_t;

endpackage

### rtl/core/cfp_in_stage.sv
`timescale 1ns / 1ps
// Input register of the command frame parser: holds one received beat.
// Depends on cfp_pkg.
module cfp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_op,
    input  logic [7:0] s_byte,
    input  logic       out_free,
    output logic       advance,
    output logic       op,
    output logic [7:0] rx_byte
);
    import cfp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic       op_reg;
    logic [7:0] byte_reg;

    assign advance  = valid_reg && out_free;
    assign s_tready = !valid_reg || advance;
    assign op       = op_reg;
    assign rx_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg   <= (s_op == OP_RESTART) ? OP_RESTART : OP_BYTE;
            byte_reg <= s_byte;
        end
    end

endmodule

### rtl/core/cfp_parser.sv
`timescale 1ns / 1ps
// Frame recognizer: phase state, length and count, first two payload bytes.
// Depends on cfp_pkg; driven by the beat held in cfp_in_stage.
module cfp_parser #(
    parameter int MAX_FRAME_LENGTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 op,
    input  logic [7:0]           rx_byte,
    output logic                 hit,
    output cfp_pkg::cfp_result_t res
);
    import cfp_pkg::*;

    localparam int LW = $clog2(MAX_FRAME_LENGTH);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SYNC1 = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_HBEAT = 3'd4;

    logic [2:0]    phase_reg,  phase_next;
    logic [LW-1:0] len_reg,    len_next;
    logic [LW-1:0] cnt_reg,    cnt_next;
    logic [7:0]    first_reg,  first_next;
    logic [7:0]    second_reg, second_next;
    logic [LW:0]   cnt_inc;

    assign cnt_inc = {1'b0, cnt_reg} + (LW+1)'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        first_next  = first_reg;
        second_next = second_reg;
        hit         = 1'b0;
        res         = '0;
        if (op == OP_RESTART)
        begin
            phase_next = PH_HUNT;
        end
        else
        begin
            case (phase_reg)
                PH_SYNC1:
                begin
                    phase_next = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_HUNT;
                end
                PH_LEN:
                begin
                    if ({1'b0, rx_byte} < 9'(MAX_FRAME_LENGTH))
                    begin
                        len_next = rx_byte[LW-1:0];
                        cnt_next = '0;
                        // empty frame ends here and never matches a command
                        phase_next = (rx_byte == 8'd0) ? PH_HUNT : PH_DATA;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_DATA:
                begin
                    if (cnt_reg == LW'(0))
                    begin
                        first_next = rx_byte;
                    end
                    if (cnt_reg == LW'(1))
                    begin
                        second_next = rx_byte;
                    end
                    cnt_next = cnt_inc[LW-1:0];
                    if (cnt_inc >= {1'b0, len_reg})
                    begin
                        phase_next = PH_HUNT;
                        if (9'(len_reg) == 9'd2 && first_next == DEG_CMD_BYTE &&
                            second_next == DEG_ARG_BYTE)
                        begin
                            hit           = 1'b1;
                            res.event_res = EV_DEGREE;
                        end
                        else if (9'(len_reg) == 9'd4 && first_next == ACK_CMD_BYTE &&
                                 (second_next == ACK_ARG1_BYTE ||
                                  second_next == ACK_ARG2_BYTE))
                        begin
                            hit           = 1'b1;
                            res.event_res = EV_ACK;
                            res.ack_code  = second_next[1:0];
                        end
                    end
                end
                PH_HBEAT:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == HB_TAIL_BYTE)
                    begin
                        hit           = 1'b1;
                        res.event_res = EV_HEART;
                    end
                end
                default:
                begin
                    // unused codes hunt as well
                    if (rx_byte == SYNC_BYTE)
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else if (rx_byte == HB_HEAD_BYTE)
                    begin
                        phase_next = PH_HBEAT;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

### rtl/core/cfp_out_reg.sv
`timescale 1ns / 1ps
// Result register of the command frame parser, master side of the stream.
// Depends on cfp_pkg.
module cfp_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 hit,
    input  cfp_pkg::cfp_result_t res,
    output logic                 out_free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output cfp_pkg::cfp_result_t m_res
);
    import cfp_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    cfp_result_t res_reg;

    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = hit;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && hit)
        begin
            res_reg <= res;
        end
    end

endmodule

### rtl/core/command_frame_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the command frame parser.
// Depends on cfp_pkg, cfp_in_stage, cfp_parser and cfp_out_reg.
//
// Byte-serial link parser. Each slave beat is one received byte (tuser = 0)
// or a link restart (tuser = 1), which drops back to hunting. It recognizes
// FE FE len payload command frames (len below MAX_FRAME_LENGTH, others
// dropped) and 27 0F heartbeats, and emits one master beat for a degree
// request (E0 00, len 2), an acknowledgement (E2 01 / E2 02, len 4, code in
// tdata) or a heartbeat; all other frames produce nothing. One byte is taken
// every clock while the result register is free: a beat passes an input register,
// a single state update and a result register, which drives the master side.
// Every byte, with or without a result, needs the result register free to move
// on; while a result waits on m_axis_tready one more byte is taken into the
// input register and the slave side then stalls.
module command_frame_parser_unit #(
    parameter int MAX_FRAME_LENGTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0] s_axis_tuser,   // [0] op
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [1:0] ack_code, [7:2] zero
    output logic [1:0] m_axis_tuser    // [1:0] event_res
);
    import cfp_pkg::*;

    logic        out_free;
    logic        advance;
    logic        op;
    logic [7:0]  rx_byte;
    logic        hit;
    cfp_result_t res;
    cfp_result_t m_res;

    cfp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_op     (s_axis_tuser[0]),
        .s_byte   (s_axis_tdata),
        .out_free (out_free),
        .advance  (advance),
        .op       (op),
        .rx_byte  (rx_byte)
    );

    cfp_parser #(
        .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .op      (op),
        .rx_byte (rx_byte),
        .hit     (hit),
        .res     (res)
    );

    cfp_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .hit      (hit),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_res    (m_res)
    );

    assign m_axis_tdata = {6'd0, m_res.ack_code};
    assign m_axis_tuser = m_res.event_res;

endmodule
